/* rtl/touch_session_tracker_macros.svh */
// assertion macros shared by the session tracker rtl
// expects a clock named clock and an active-high reset named reset in scope
`ifndef TOUCH_SESSION_TRACKER_MACROS_SVH
`define TOUCH_SESSION_TRACKER_MACROS_SVH

// same-cycle implication
`define TST_ASSERT_IMP(lbl, ante, cons) \
lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
   else $error("session tracker assertion failed");

// next-cycle implication
`define TST_ASSERT_NXT(lbl, ante, cons) \
lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error("session tracker assertion failed");

`endif

/* rtl/tst_pkg.sv */
// shared types and constants of the session tracker
// no dependencies
package tst_pkg;

   localparam int SLOTS_DEFAULT = 16;
   localparam int ID_W          = 32;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;

   localparam logic [1:0] CMD_SET   = 2'd0;
   localparam logic [1:0] CMD_ALIVE = 2'd1;
   localparam logic [1:0] CMD_END   = 2'd2;

   localparam logic [1:0] RES_NEW    = 2'd0;
   localparam logic [1:0] RES_MOVE   = 2'd1;
   localparam logic [1:0] RES_REMOVE = 2'd2;
   localparam logic [1:0] RES_FULL   = 2'd3;

   // register index, taken from paddr[2]
   localparam logic REG_ENABLE = 1'b0;

   typedef struct packed {
      logic            used;
      logic            seen;
      logic [ID_W-1:0] id;
   } entry_type;

   // one slot of both tables, indexed by kind
   typedef entry_type [1:0] slot_type;

endpackage

/* rtl/touch_session_tracker.sv */
// Session tracker for cursor and object session ids.
// Input channel req_*: one transfer per message (set, alive id, end of alive list).
// Result channel rsp_*: new, move, remove and table-full events; rsp_last marks
// the final event of a message. Both channels use valid/stall.
// Both tables live in a ring of SLOTS cells that rotates one cell per cycle while
// a message is scanned or inserted, unless a removal waits on a stalled receiver;
// the controller looks at the head cell and writes the entry back at the tail, so
// each enabled set, alive or end message costs one full turn of the ring and then
// the finish state; a set that inserts then takes a second turn, which brings the
// lowest free slot to the head, and the finish state again. A set's event is sent
// from its last finish state; removals come out during the sweep and the finish
// state. A result waiting in the output register does not block taking the next
// message; a stalled receiver halts the ring only when another result must be sent.
// Reset clears all used and seen bits at once and sets enable; the block is
// ready as soon as reset is released. With enable low messages are taken and
// dropped. csr register 0 (byte address 0): bit 0 enable.
module touch_session_tracker #(
   parameter int SLOTS = tst_pkg::SLOTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_cmd,
   input  logic                              req_kind,
   input  logic signed [tst_pkg::ID_W-1:0]   req_session_id,
   input  logic signed [tst_pkg::ID_W-1:0]   req_class_id,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_event_res,
   output logic                              rsp_event_kind,
   output logic signed [tst_pkg::ID_W-1:0]   rsp_event_session,
   output logic signed [tst_pkg::ID_W-1:0]   rsp_event_class,
   output logic                              rsp_last,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tst_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [tst_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [tst_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

`include "touch_session_tracker_macros.svh"

   localparam int CW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [CW-1:0] LAST_SLOT = CW'(SLOTS - 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH, ST_INSERT} state_type;

   // configuration
   logic enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == tst_pkg::REG_ENABLE) begin
         enable_ff <= csr_pwdata[0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == tst_pkg::REG_ENABLE) ?
                       {{(tst_pkg::CSR_DATA_W-1){1'b0}}, enable_ff} : '0;

   // ring of cells
   tst_pkg::slot_type chain_q [SLOTS];
   tst_pkg::slot_type wb;
   logic              shift_en;

   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      if (g == SLOTS - 1) begin : g_tail
         tst_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .slot_in  (wb),
            .slot_out (chain_q[g])
         );
      end else begin : g_mid
         tst_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (shift_en),
            .slot_in  (chain_q[g+1]),
            .slot_out (chain_q[g])
         );
      end
   end

   // controller state
   state_type                  state_ff, state_in;
   logic [CW-1:0]              cnt_ff, cnt_in;
   logic [1:0]                 cmd_ff, cmd_in;
   logic                       kind_ff, kind_in;
   logic [tst_pkg::ID_W-1:0]   sess_ff, sess_in;
   logic [tst_pkg::ID_W-1:0]   cls_ff, cls_in;
   logic                       hit_ff, hit_in;
   logic                       free_found_ff, free_found_in;
   logic [CW-1:0]              free_idx_ff, free_idx_in;
   logic                       inserted_ff, inserted_in;
   logic                       pend_valid_ff, pend_valid_in;
   logic [tst_pkg::ID_W-1:0]   pend_id_ff, pend_id_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0]                 rsp_res_ff, rsp_res_in;
   logic                       rsp_kind_ff, rsp_kind_in;
   logic [tst_pkg::ID_W-1:0]   rsp_sess_ff, rsp_sess_in;
   logic [tst_pkg::ID_W-1:0]   rsp_cls_ff, rsp_cls_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       out_free;
   logic                       emit;
   logic [1:0]                 emit_res;
   logic [tst_pkg::ID_W-1:0]   emit_sess;
   logic [tst_pkg::ID_W-1:0]   emit_cls;
   logic                       emit_last;
   logic [tst_pkg::ID_W-1:0]   pass_cls;
   logic [CW-1:0]              cnt_next;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pass_cls = kind_ff ? cls_ff : '0;
   assign cnt_next = (cnt_ff == LAST_SLOT) ? '0 : cnt_ff + 1'b1;

   always_comb begin
      tst_pkg::entry_type he;
      logic               rm;

      he            = chain_q[0][kind_ff];
      rm            = he.used && !he.seen;
      wb            = chain_q[0];
      shift_en      = 1'b0;
      emit          = 1'b0;
      emit_res      = tst_pkg::RES_NEW;
      emit_sess     = sess_ff;
      emit_cls      = '0;
      emit_last     = 1'b1;
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      cmd_in        = cmd_ff;
      kind_in       = kind_ff;
      sess_in       = sess_ff;
      cls_in        = cls_ff;
      hit_in        = hit_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      inserted_in   = inserted_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_cmd;
               kind_in       = req_kind;
               sess_in       = $unsigned(req_session_id);
               cls_in        = $unsigned(req_class_id);
               cnt_in        = '0;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               inserted_in   = 1'b0;
               pend_valid_in = 1'b0;
               if (enable_ff && (req_cmd == tst_pkg::CMD_SET ||
                                 req_cmd == tst_pkg::CMD_ALIVE ||
                                 req_cmd == tst_pkg::CMD_END)) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // a second removal must push out the held one before the ring moves
            if (!(cmd_ff == tst_pkg::CMD_END && rm && pend_valid_ff && !out_free)) begin
               shift_en = 1'b1;
               cnt_in   = cnt_next;
               if (cnt_ff == LAST_SLOT) begin
                  state_in = ST_FINISH;
               end
               case (cmd_ff)
                  tst_pkg::CMD_SET: begin
                     if (he.used && he.id == sess_ff) begin
                        hit_in = 1'b1;
                     end
                     if (!he.used && !free_found_ff) begin
                        free_found_in = 1'b1;
                        free_idx_in   = cnt_ff;
                     end
                  end
                  tst_pkg::CMD_ALIVE: begin
                     if (he.used && he.id == sess_ff) begin
                        wb[kind_ff].seen = 1'b1;
                     end
                  end
                  tst_pkg::CMD_END: begin
                     wb[kind_ff].seen = 1'b0;
                     if (rm) begin
                        wb[kind_ff].used = 1'b0;
                        if (pend_valid_ff) begin
                           emit      = 1'b1;
                           emit_res  = tst_pkg::RES_REMOVE;
                           emit_sess = pend_id_ff;
                           emit_last = 1'b0;
                        end
                        pend_valid_in = 1'b1;
                        pend_id_in    = he.id;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FINISH: begin
            case (cmd_ff)
               tst_pkg::CMD_SET: begin
                  if (hit_ff) begin
                     if (out_free) begin
                        emit     = 1'b1;
                        emit_res = tst_pkg::RES_MOVE;
                        emit_cls = pass_cls;
                        state_in = ST_IDLE;
                     end
                  end else if (free_found_ff && !inserted_ff) begin
                     state_in = ST_INSERT;
                     cnt_in   = '0;
                  end else if (out_free) begin
                     emit     = 1'b1;
                     emit_res = inserted_ff ? tst_pkg::RES_NEW : tst_pkg::RES_FULL;
                     emit_cls = inserted_ff ? pass_cls : '0;
                     state_in = ST_IDLE;
                  end
               end
               tst_pkg::CMD_END: begin
                  if (!pend_valid_ff) begin
                     state_in = ST_IDLE;
                  end else if (out_free) begin
                     emit          = 1'b1;
                     emit_res      = tst_pkg::RES_REMOVE;
                     emit_sess     = pend_id_ff;
                     emit_last     = 1'b1;
                     pend_valid_in = 1'b0;
                     state_in      = ST_IDLE;
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_INSERT: begin
            shift_en = 1'b1;
            cnt_in   = cnt_next;
            if (cnt_ff == free_idx_ff) begin
               wb[kind_ff].used = 1'b1;
               wb[kind_ff].seen = 1'b0;
               wb[kind_ff].id   = sess_ff;
               inserted_in      = 1'b1;
            end
            if (cnt_ff == LAST_SLOT) begin
               state_in = ST_FINISH;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // output register
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_res_in   = rsp_res_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_sess_in  = rsp_sess_ff;
      rsp_cls_in   = rsp_cls_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = emit_res;
         rsp_kind_in  = kind_ff;
         rsp_sess_in  = emit_sess;
         rsp_cls_in   = emit_cls;
         rsp_last_in  = emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         hit_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         inserted_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         hit_ff        <= hit_in;
         free_found_ff <= free_found_in;
         inserted_ff   <= inserted_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      kind_ff     <= kind_in;
      sess_ff     <= sess_in;
      cls_ff      <= cls_in;
      free_idx_ff <= free_idx_in;
      pend_id_ff  <= pend_id_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_sess_ff <= rsp_sess_in;
      rsp_cls_ff  <= rsp_cls_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_stall         = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_res     = rsp_res_ff;
   assign rsp_event_kind    = rsp_kind_ff;
   assign rsp_event_session = $signed(rsp_sess_ff);
   assign rsp_event_class   = $signed(rsp_cls_ff);
   assign rsp_last          = rsp_last_ff;

   `TST_ASSERT_IMP(a_emit_room, emit, out_free)
   `TST_ASSERT_NXT(a_emit_shows, emit, rsp_valid_ff)
   `TST_ASSERT_IMP(a_insert_only_on_miss, state_ff == ST_INSERT, !hit_ff && free_found_ff)
   `TST_ASSERT_IMP(a_pend_only_sweep, pend_valid_ff, cmd_ff == tst_pkg::CMD_END)
   `TST_ASSERT_IMP(a_ring_idle_still, state_ff == ST_IDLE || state_ff == ST_FINISH, !shift_en)

endmodule

/* rtl/tst_cell.sv */
// one slot cell of the rotating session table, holds the cursor and object entry
// depends on tst_pkg
module tst_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  tst_pkg::slot_type slot_in,
   output tst_pkg::slot_type slot_out
);

   tst_pkg::slot_type slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 2; k++) begin
            slot_ff[k].used <= 1'b0;
            slot_ff[k].seen <= 1'b0;
         end
      end else if (shift_en) begin
         slot_ff <= slot_in;
      end
   end

   assign slot_out = slot_ff;

endmodule

/* sim/touch_session_tracker_checker.sv */
// checker for the session tracker: tracks csr writes and accepted messages,
// keeps its own copy of both session tables and compares every event transfer
// depends on tst_pkg for widths, commands, event codes and the csr register index
module touch_session_tracker_checker #(
   parameter int SLOTS = tst_pkg::SLOTS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [1:0]                        req_cmd,
   input  logic                              req_kind,
   input  logic [tst_pkg::ID_W-1:0]          req_session_id,
   input  logic [tst_pkg::ID_W-1:0]          req_class_id,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic [1:0]                        rsp_event_res,
   input  logic                              rsp_event_kind,
   input  logic [tst_pkg::ID_W-1:0]          rsp_event_session,
   input  logic [tst_pkg::ID_W-1:0]          rsp_event_class,
   input  logic                              rsp_last,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tst_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [tst_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   input  logic                              csr_pready,
   output int                                errors,
   output int                                outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [tst_pkg::CSR_ADDR_W-1:0] ENABLE_ADDR = {tst_pkg::REG_ENABLE, 2'b00};

   typedef struct packed {
      logic [1:0]               res;
      logic                     kind;
      logic [tst_pkg::ID_W-1:0] session;
      logic [tst_pkg::ID_W-1:0] cls;
      logic                     last;
   } session_event_type;

   session_event_type        pending_events[$];
   session_event_type        want;
   logic [tst_pkg::ID_W-1:0] slot_id   [2][SLOTS];
   logic                     slot_used [2][SLOTS];
   logic                     slot_seen [2][SLOTS];
   logic                     enable_now;
   int                       err_count = 0;

   function automatic void add_event(input logic [1:0] res, input logic kind,
                                     input logic [tst_pkg::ID_W-1:0] sess,
                                     input logic [tst_pkg::ID_W-1:0] cls,
                                     input logic last);
      session_event_type ev;
      ev.res = res;
      ev.kind = kind;
      ev.session = sess;
      ev.cls = cls;
      ev.last = last;
      pending_events.insert(pending_events.size(), ev);
   endfunction

   // updates the table of the message's kind and queues the events it causes
   function automatic void track_message(input logic [1:0] cmd, input logic kind,
                                         input logic [tst_pkg::ID_W-1:0] sess,
                                         input logic [tst_pkg::ID_W-1:0] cls);
      int hit = -1;
      int free = -1;
      int removed = 0;
      logic [tst_pkg::ID_W-1:0] pass_cls;
      if (!enable_now) return;
      pass_cls = kind ? cls : '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (slot_used[kind][i] && slot_id[kind][i] == sess && hit < 0) hit = i;
         if (!slot_used[kind][i] && free < 0) free = i;
      end
      case (cmd)
         tst_pkg::CMD_SET: begin
            if (hit >= 0) begin
               add_event(tst_pkg::RES_MOVE, kind, sess, pass_cls, 1'b1);
            end else if (free >= 0) begin
               slot_used[kind][free] = 1'b1;
               slot_seen[kind][free] = 1'b0;
               slot_id[kind][free] = sess;
               add_event(tst_pkg::RES_NEW, kind, sess, pass_cls, 1'b1);
            end else begin
               add_event(tst_pkg::RES_FULL, kind, sess, '0, 1'b1);
            end
         end
         tst_pkg::CMD_ALIVE: begin
            if (hit >= 0) slot_seen[kind][hit] = 1'b1;
         end
         tst_pkg::CMD_END: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (slot_used[kind][i] && !slot_seen[kind][i]) begin
                  slot_used[kind][i] = 1'b0;
                  add_event(tst_pkg::RES_REMOVE, kind, slot_id[kind][i], '0, 1'b0);
                  removed++;
               end
               slot_seen[kind][i] = 1'b0;
            end
            if (removed > 0) pending_events[pending_events.size()-1].last = 1'b1;
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 2; k++) begin
            for (int i = 0; i < SLOTS; i++) begin
               slot_id[k][i] = '0;
               slot_used[k][i] = 1'b0;
               slot_seen[k][i] = 1'b0;
            end
         end
         enable_now = 1'b1;
         pending_events.delete();
      end else begin
         // a message taken at the edge of a csr write still sees the old enable
         if (req_valid && !req_stall)
            track_message(req_cmd, req_kind, req_session_id, req_class_id);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == ENABLE_ADDR)
            enable_now = csr_pwdata[0];
         if (rsp_valid && !rsp_stall) begin
            if (pending_events.size() == 0) begin
               if (err_count < 10)
                  $display("checker: unexpected event res %0d kind %0d session %h class %h last %0d",
                           rsp_event_res, rsp_event_kind, rsp_event_session,
                           rsp_event_class, rsp_last);
               err_count++;
            end else begin
               want = pending_events.pop_front();
               if (want.res !== rsp_event_res || want.kind !== rsp_event_kind ||
                   want.session !== rsp_event_session || want.cls !== rsp_event_class ||
                   want.last !== rsp_last) begin
                  if (err_count < 10) begin
                     $display("checker: expected res %0d kind %0d session %h class %h last %0d",
                              want.res, want.kind, want.session, want.cls, want.last);
                     $display("checker:      got res %0d kind %0d session %h class %h last %0d",
                              rsp_event_res, rsp_event_kind, rsp_event_session,
                              rsp_event_class, rsp_last);
                  end
                  err_count++;
               end
            end
         end
      end
      // registered so the stimulus side reads a settled value after each edge
      errors <= err_count;
      outstanding <= pending_events.size();
   end

endmodule

/* sim/tb_touch_session_tracker.sv */
// top of the session tracker testbench: clock, reset, csr writes, message
// stimulus, result-side stalls and the verdict
// depends on tst_pkg, touch_session_tracker and touch_session_tracker_checker
module tb_touch_session_tracker;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS = tst_pkg::SLOTS_DEFAULT;
   localparam int ID_W = tst_pkg::ID_W;
   localparam int CSR_ADDR_W = tst_pkg::CSR_ADDR_W;
   localparam int CSR_DATA_W = tst_pkg::CSR_DATA_W;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam logic KIND_CURSOR = 1'b0;
   localparam logic KIND_OBJECT = 1'b1;
   localparam logic [CSR_ADDR_W-1:0] ENABLE_ADDR = {tst_pkg::REG_ENABLE, 2'b00};
   localparam int RANDOM_ITEMS = 100;
   // one message takes at most two turns of the ring
   localparam int SETTLE_CYCLES = 2*SLOTS + 8;
   localparam int HOLD_CYCLES = 400;
   localparam int LIMIT_CYCLES = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_cmd = tst_pkg::CMD_SET;
   logic req_kind = KIND_CURSOR;
   logic [ID_W-1:0] req_session_id = '0;
   logic [ID_W-1:0] req_class_id = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_event_res;
   logic rsp_event_kind;
   logic [ID_W-1:0] rsp_event_session;
   logic [ID_W-1:0] rsp_event_class;
   logic rsp_last;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   int errors;
   int outstanding;
   int transfers_sent = 0;
   int useful_sent = 0;
   int cycle_count = 0;
   logic [ID_W-1:0] id_pool [2][8];

   always #6 clock = ~clock;

   touch_session_tracker #(.SLOTS(SLOTS)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_kind(req_kind), .req_session_id(req_session_id),
      .req_class_id(req_class_id),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_event_res(rsp_event_res),
      .rsp_event_kind(rsp_event_kind), .rsp_event_session(rsp_event_session),
      .rsp_event_class(rsp_event_class), .rsp_last(rsp_last),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   touch_session_tracker_checker #(.SLOTS(SLOTS)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_cmd(req_cmd),
      .req_kind(req_kind), .req_session_id(req_session_id),
      .req_class_id(req_class_id),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_event_res(rsp_event_res),
      .rsp_event_kind(rsp_event_kind), .rsp_event_session(rsp_event_session),
      .rsp_event_class(rsp_event_class), .rsp_last(rsp_last),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .errors(errors), .outstanding(outstanding)
   );

   // both sides run without gaps over this window of transfers
   function automatic bit calm();
      return transfers_sent >= 100 && transfers_sent < 150;
   endfunction

   task automatic send_item(input logic [1:0] cmd, input logic kind,
                            input logic [ID_W-1:0] sess, input logic [ID_W-1:0] cls);
      while (!calm() && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_kind <= kind;
      req_session_id <= sess;
      req_class_id <= cls;
      do @(posedge clock); while (req_stall);
      transfers_sent++;
      if (cmd != CMD_UNUSED) useful_sent++;
   endtask

   task automatic write_enable(input logic value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ENABLE_ADDR;
      csr_pwdata <= {{(CSR_DATA_W-1){1'b0}}, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // drain all expected events, then give the ring time to finish silent messages
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // sets from a small id pool, some alive ids, maybe a late set, then the end
   task automatic run_frame();
      logic k;
      int n;
      k = 1'($urandom_range(1));
      if ($urandom_range(3) == 0) id_pool[k][3'($urandom_range(7))] = $urandom();
      n = $urandom_range(1, 6);
      repeat (n)
         send_item(tst_pkg::CMD_SET, k, id_pool[k][3'($urandom_range(7))], $urandom());
      n = $urandom_range(0, 6);
      repeat (n)
         send_item(tst_pkg::CMD_ALIVE, k, id_pool[k][3'($urandom_range(7))], $urandom());
      if ($urandom_range(3) == 0) send_item(tst_pkg::CMD_SET, k, $urandom(), $urandom());
      send_item(tst_pkg::CMD_END, k, $urandom(), $urandom());
   endtask

   // overflow the table with fresh ids, then sweep every slot out
   task automatic run_fill();
      logic k;
      k = 1'($urandom_range(1));
      repeat (SLOTS + 2) send_item(tst_pkg::CMD_SET, k, $urandom(), $urandom());
      send_item(tst_pkg::CMD_END, k, $urandom(), $urandom());
   endtask

   initial begin
      for (int k = 0; k < 2; k++)
         for (int i = 0; i < 8; i++) id_pool[k][i] = $urandom();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_enable(1'b1);

      send_item(tst_pkg::CMD_SET, KIND_CURSOR, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(tst_pkg::CMD_SET, KIND_CURSOR, 32'hFFFF_FFFF, $urandom());
      send_item(tst_pkg::CMD_SET, KIND_CURSOR, 32'h7FFF_FFFF, 32'h8000_0000);
      send_item(tst_pkg::CMD_SET, KIND_CURSOR, 32'h8000_0000, 32'h7FFF_FFFF);
      send_item(tst_pkg::CMD_SET, KIND_CURSOR, 32'h0000_0000, 32'h0000_0000);
      send_item(tst_pkg::CMD_SET, KIND_OBJECT, 32'h0000_0000, 32'h8000_0000);
      send_item(tst_pkg::CMD_SET, KIND_OBJECT, 32'h0000_0001, 32'h7FFF_FFFF);
      send_item(tst_pkg::CMD_SET, KIND_OBJECT, 32'h0000_0001, 32'hFFFF_FFFF);
      send_item(tst_pkg::CMD_ALIVE, KIND_CURSOR, 32'h0000_0000, $urandom());
      // unknown id on the alive list
      send_item(tst_pkg::CMD_ALIVE, KIND_CURSOR, 32'h0001_2345, $urandom());
      send_item(tst_pkg::CMD_ALIVE, KIND_CURSOR, 32'h7FFF_FFFF, $urandom());
      // new id between alive list and its end starts unseen
      send_item(tst_pkg::CMD_SET, KIND_CURSOR, 32'h0000_0555, $urandom());
      send_item(tst_pkg::CMD_END, KIND_CURSOR, $urandom(), $urandom());
      send_item(tst_pkg::CMD_END, KIND_CURSOR, $urandom(), $urandom());
      // nothing left to sweep
      send_item(tst_pkg::CMD_END, KIND_CURSOR, $urandom(), $urandom());
      send_item(CMD_UNUSED, KIND_OBJECT, $urandom(), $urandom());
      send_item(tst_pkg::CMD_ALIVE, KIND_OBJECT, 32'h0000_0000, $urandom());
      send_item(tst_pkg::CMD_END, KIND_OBJECT, $urandom(), $urandom());
      send_item(tst_pkg::CMD_END, KIND_OBJECT, $urandom(), $urandom());
      settle();

      write_enable(1'b0);
      repeat (10)
         send_item(2'($urandom_range(3)), 1'($urandom_range(1)), $urandom(), $urandom());
      settle();
      write_enable(1'b1);

      begin : random_phase
         int start;
         int pick;
         start = useful_sent;
         while (useful_sent - start < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 75) run_frame();
            else if (pick < 85) run_fill();
            else send_item(2'($urandom_range(3)), 1'($urandom_range(1)),
                           $urandom(), $urandom());
         end
      end
      settle();

      if (errors == 0 && outstanding == 0) begin
         $display("[touch_session_tracker] OK");
      end else begin
         $display("[touch_session_tracker] ERROR");
      end
      $finish;
   end

   // result side: random stalls, one long hold-off so the block backs up
   initial begin : receiver
      int hold_left;
      bit held;
      hold_left = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!held && transfers_sent >= 70) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !calm() && $urandom_range(99) < 21;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("[touch_session_tracker] ERROR");
         $finish;
      end
   end

endmodule
